/* hdl/prw_pkg.sv */
// shared widths, op codes and verdict codes for the packet replay window
`timescale 1ns / 1ps
`default_nettype none
package prw_pkg;

  localparam int PRW_WINDOW_BITS = 64;
  localparam int ID_W = 32;
  localparam int CNT_W = 32;
  localparam int CFG_W = 7;
  localparam int OP_W = 2;
  localparam int VERDICT_W = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [VERDICT_W-1:0] VERDICT_FRESH = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SEEN = 2'd2;

endpackage
`default_nettype wire

/* hdl/prw_if.sv */
// request and response channel interfaces of the packet replay window
`timescale 1ns / 1ps
`default_nettype none
interface prw_req_if import prw_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] op;
  logic [ID_W-1:0] seq_id;

  modport source (output valid, output op, output seq_id, input ready);
  modport sink (input valid, input op, input seq_id, output ready);
endinterface

interface prw_rsp_if import prw_pkg::*; ();
  logic valid;
  logic ready;
  logic replay;
  logic [VERDICT_W-1:0] verdict;
  logic [ID_W-1:0] highest_seen;
  logic [CNT_W-1:0] checks_done;
  logic [CNT_W-1:0] replays_found;

  modport source (output valid, output replay, output verdict, output highest_seen,
                  output checks_done, output replays_found, input ready);
  modport sink (input valid, input replay, input verdict, input highest_seen,
                input checks_done, input replays_found, output ready);
endinterface
`default_nettype wire

/* hdl/packet_replay_window_core.sv */
// Anti-replay sliding window over 32-bit packet ids. Each request (check, mark or clear)
// is accepted on a handshake and its response appears in the output register on the next
// cycle; a new request is accepted every cycle as long as the response register is empty
// or being drained in that same cycle, so sustained throughput is one request per clock.
// The check, the bitmap shift and the counter updates are all done in the accepting cycle.
// The user writes window_in_use through cfg_we/cfg_wdata only while idle; the block
// does not enforce this. 0 acts as 1 and values above WINDOW_BITS act as WINDOW_BITS.
`timescale 1ns / 1ps
`default_nettype none
module packet_replay_window_core
  import prw_pkg::*;
#(
  parameter int WINDOW_BITS = PRW_WINDOW_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  prw_req_if.sink               req,
  prw_rsp_if.source             rsp
);

  localparam int IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int WIN_MAX = (WINDOW_BITS < (2 ** CFG_W - 1)) ? WINDOW_BITS : (2 ** CFG_W - 1);

  logic [CFG_W-1:0] window_in_use;
  logic [ID_W-1:0] highest_id, highest_id_next;
  logic [WINDOW_BITS-1:0] seen_bitmap, seen_bitmap_next;
  logic [CNT_W-1:0] check_counter, check_counter_next;
  logic [CNT_W-1:0] replay_counter, replay_counter_next;
  logic out_valid;

  logic accept;
  logic [CFG_W-1:0] win_eff;
  logic [WINDOW_BITS-1:0] win_mask;
  logic [WINDOW_BITS-1:0] shifted;
  logic [ID_W:0] id_plus_win;
  logic [ID_W-1:0] fwd_gap;
  logic [ID_W-1:0] back_off;
  logic gap_in_win;
  logic back_in_win;
  logic [VERDICT_W-1:0] verdict_next;

  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept = req.valid && req.ready;

  always_comb begin
    if (window_in_use == '0) begin
      win_eff = CFG_W'(1);
    end else if (window_in_use > CFG_W'(WIN_MAX)) begin
      win_eff = CFG_W'(WIN_MAX);
    end else begin
      win_eff = window_in_use;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_BITS; i++) begin
      win_mask[i] = (32'(i) < 32'(win_eff));
    end
  end

  assign id_plus_win = {1'b0, req.seq_id} + (ID_W + 1)'(win_eff);
  assign fwd_gap = req.seq_id - highest_id;
  assign back_off = highest_id - req.seq_id;
  assign gap_in_win = (fwd_gap < ID_W'(win_eff));
  assign back_in_win = (back_off < ID_W'(win_eff));
  // distance is below the window here, so the low bits carry it whole
  assign shifted = (seen_bitmap << fwd_gap[CFG_W-1:0]) & win_mask;

  always_comb begin
    highest_id_next = highest_id;
    seen_bitmap_next = seen_bitmap;
    check_counter_next = check_counter;
    replay_counter_next = replay_counter;
    verdict_next = VERDICT_FRESH;
    unique case (req.op)
      OP_CHECK: begin
        check_counter_next = check_counter + CNT_W'(1);
        if (highest_id != '0) begin
          if (id_plus_win <= {1'b0, highest_id}) begin
            verdict_next = VERDICT_TOO_OLD;
          end else if (req.seq_id <= highest_id &&
                       seen_bitmap[back_off[IDX_W-1:0]]) begin
            // not too old implies the offset is inside the window
            verdict_next = VERDICT_SEEN;
          end
        end
        if (verdict_next != VERDICT_FRESH) begin
          replay_counter_next = replay_counter + CNT_W'(1);
        end
      end
      OP_MARK: begin
        if (req.seq_id > highest_id) begin
          highest_id_next = req.seq_id;
          seen_bitmap_next = gap_in_win ? shifted : '0;
          seen_bitmap_next[0] = 1'b1;
        end else begin
          for (int i = 0; i < WINDOW_BITS; i++) begin
            if (back_in_win && back_off[IDX_W-1:0] == IDX_W'(i)) begin
              seen_bitmap_next[i] = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: begin
        highest_id_next = '0;
        seen_bitmap_next = '0;
        check_counter_next = '0;
        replay_counter_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      window_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_id <= '0;
      seen_bitmap <= '0;
      check_counter <= '0;
      replay_counter <= '0;
    end else if (accept) begin
      highest_id <= highest_id_next;
      seen_bitmap <= seen_bitmap_next;
      check_counter <= check_counter_next;
      replay_counter <= replay_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.replay <= (verdict_next != VERDICT_FRESH);
      rsp.verdict <= verdict_next;
      rsp.highest_seen <= highest_id_next;
      rsp.checks_done <= check_counter_next;
      rsp.replays_found <= replay_counter_next;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

/* hdl/prw_checker.sv */
// port-level checker for the packet replay window, bound to the window core
`timescale 1ns / 1ps
`default_nettype none
module prw_checker
  import prw_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic [OP_W-1:0]      req_op,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic                 rsp_replay,
  input wire logic [VERDICT_W-1:0] rsp_verdict,
  input wire logic [ID_W-1:0]      rsp_highest_seen,
  input wire logic [CNT_W-1:0]     rsp_checks_done,
  input wire logic [CNT_W-1:0]     rsp_replays_found
);

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // a stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_op == OP_CLEAR |=>
      rsp_valid && rsp_highest_seen == '0 && rsp_checks_done == '0 &&
      rsp_replays_found == '0)
    else $error("clear request did not empty the window and counters");

  a_verdict_only_on_check: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_op != OP_CHECK |=> rsp_verdict == VERDICT_FRESH && !rsp_replay)
    else $error("verdict reported for a request that is not a check");

  a_replay_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_replay == (rsp_verdict != VERDICT_FRESH))
    else $error("replay flag disagrees with verdict");

endmodule

bind packet_replay_window_core prw_checker u_prw_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_op            (req.op),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_replay        (rsp.replay),
  .rsp_verdict       (rsp.verdict),
  .rsp_highest_seen  (rsp.highest_seen),
  .rsp_checks_done   (rsp.checks_done),
  .rsp_replays_found (rsp.replays_found)
);
`default_nettype wire
